FILE: hw/rtl/sdes_pkg.sv
// Shared width helpers for the stream difference error statistics block.
package sdes_pkg;

  // Widest running sum kept by the block
  localparam int SumCapBits = 62;

  // Width of the absolute-difference sum and of the sum of originals
  function automatic int acc_bits(input int sample_bits, input int index_bits);
    int raw;
    raw = sample_bits + index_bits;
    return (raw > SumCapBits) ? SumCapBits : raw;
  endfunction

  // Width of the squared-difference sum
  function automatic int sq_bits(input int sample_bits, input int index_bits);
    int raw;
    raw = 2 * sample_bits + index_bits;
    return (raw > SumCapBits) ? SumCapBits : raw;
  endfunction

endpackage

FILE: hw/rtl/sdes_in_if.sv
// Input channel: one original/decoded sample pair with a dataset end flag.
interface sdes_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] original_sample;
  logic signed [SAMPLE_BITS-1:0] decoded_sample;
  logic                          last;

  modport source (output valid, output original_sample, output decoded_sample, output last,
                  input ready);
  modport sink   (input valid, input original_sample, input decoded_sample, input last,
                  output ready);
endinterface

FILE: hw/rtl/sdes_out_if.sv
// Result channel: per-element difference with the running dataset statistics.
interface sdes_out_if import sdes_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 24
);
  localparam int DiffBits = SAMPLE_BITS + 1;
  localparam int AccBits  = acc_bits(SAMPLE_BITS, INDEX_BITS);
  localparam int SqBits   = sq_bits(SAMPLE_BITS, INDEX_BITS);

  logic                          valid;
  logic                          ready;
  logic signed [DiffBits-1:0]    difference;
  logic                          final_res;
  logic [AccBits-1:0]            sum_abs_diff;
  logic signed [AccBits-1:0]     sum_orig;
  logic [SqBits-1:0]             sum_sq_diff;
  logic signed [DiffBits-1:0]    min_diff;
  logic signed [DiffBits-1:0]    max_diff;
  logic [INDEX_BITS-1:0]         min_diff_index;
  logic [INDEX_BITS-1:0]         max_diff_index;
  logic signed [SAMPLE_BITS-1:0] min_orig;
  logic signed [SAMPLE_BITS-1:0] max_orig;

  modport source (output valid, output difference, output final_res, output sum_abs_diff,
                  output sum_orig, output sum_sq_diff, output min_diff, output max_diff,
                  output min_diff_index, output max_diff_index, output min_orig,
                  output max_orig, input ready);
  modport sink   (input valid, input difference, input final_res, input sum_abs_diff,
                  input sum_orig, input sum_sq_diff, input min_diff, input max_diff,
                  input min_diff_index, input max_diff_index, input min_orig,
                  input max_orig, output ready);
endinterface

FILE: hw/rtl/stream_difference_error_stats.sv
// Stream difference error statistics: per-pair difference plus running dataset statistics.
//
// Takes one original/decoded sample pair per cycle unless the result channel stalls
// and returns, for every pair, original minus decoded together with the running sum
// of absolute differences, the sum of originals, the sum of squared differences, the
// difference extremes with the latest index holding each, and the original extremes.
// The pair after one flagged last opens a new dataset. Throughput is one pair per clock
// while results are accepted; a pair passes the input register with subtract, the
// squaring multiplier stage and the statistics stage before its result appears. The
// rate is set by the statistics stage, whose accumulate and compare feedback closes on
// its own registers. Sums and the element index saturate. A stalled result holds while
// earlier stages keep filling.
module stream_difference_error_stats import sdes_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 24
) (
  input logic        clk,
  input logic        rst,
  sdes_in_if.sink    samples,
  sdes_out_if.source results
);

  localparam int DiffBits = SAMPLE_BITS + 1;
  localparam int MulBits  = 2 * SAMPLE_BITS;
  localparam int AccBits  = acc_bits(SAMPLE_BITS, INDEX_BITS);
  localparam int SqBits   = sq_bits(SAMPLE_BITS, INDEX_BITS);

  // Stage A: difference
  logic                          a_valid;
  logic signed [DiffBits-1:0]    a_diff;
  logic signed [SAMPLE_BITS-1:0] a_orig;
  logic                          a_last;
  logic [DiffBits-1:0]           a_mag_full;
  logic [SAMPLE_BITS-1:0]        a_mag;
  logic                          a_ready;

  // Stage B: magnitude and square
  logic                          b_valid;
  logic signed [DiffBits-1:0]    b_diff;
  logic signed [SAMPLE_BITS-1:0] b_orig;
  logic                          b_last;
  logic [SAMPLE_BITS-1:0]        b_mag;
  logic [MulBits-1:0]            b_sq;
  logic                          b_ready;

  // Result register, doubling as the statistics state
  logic                          out_valid;
  logic                          out_free;
  logic signed [DiffBits-1:0]    out_diff;
  logic                          out_last;
  logic                          first_flag;
  logic [INDEX_BITS-1:0]         element_count;
  logic [AccBits-1:0]            acc_abs;
  logic signed [AccBits-1:0]     acc_orig;
  logic [SqBits-1:0]             acc_sq;
  logic signed [DiffBits-1:0]    diff_low;
  logic signed [DiffBits-1:0]    diff_high;
  logic [INDEX_BITS-1:0]         diff_low_pos;
  logic [INDEX_BITS-1:0]         diff_high_pos;
  logic signed [SAMPLE_BITS-1:0] orig_low;
  logic signed [SAMPLE_BITS-1:0] orig_high;

  // Next statistics
  logic [INDEX_BITS-1:0]         idx;
  logic [INDEX_BITS-1:0]         element_count_next;
  logic [AccBits-1:0]            abs_base;
  logic [AccBits:0]              abs_sum;
  logic [AccBits-1:0]            acc_abs_next;
  logic [SqBits-1:0]             sq_base;
  logic [SqBits:0]               sq_sum;
  logic [SqBits-1:0]             acc_sq_next;
  logic signed [AccBits-1:0]     orig_base;
  logic signed [AccBits:0]       orig_sum;
  logic signed [AccBits-1:0]     acc_orig_next;
  logic signed [DiffBits-1:0]    diff_low_next;
  logic signed [DiffBits-1:0]    diff_high_next;
  logic [INDEX_BITS-1:0]         diff_low_pos_next;
  logic [INDEX_BITS-1:0]         diff_high_pos_next;
  logic signed [SAMPLE_BITS-1:0] orig_low_next;
  logic signed [SAMPLE_BITS-1:0] orig_high_next;

  // Backpressure chain: a stage advances when it is empty or the next one advances
  assign out_free      = !out_valid || results.ready;
  assign b_ready       = !b_valid || out_free;
  assign a_ready       = !a_valid || b_ready;
  assign samples.ready = a_ready;

  // Magnitude of the difference always fits the sample width
  assign a_mag_full = a_diff[DiffBits-1] ? DiffBits'(-a_diff) : DiffBits'(a_diff);
  assign a_mag      = a_mag_full[SAMPLE_BITS-1:0];

  // Stage A: capture the pair and subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= samples.valid;
    end
    if (samples.valid && a_ready) begin
      a_diff <= DiffBits'(samples.original_sample) - DiffBits'(samples.decoded_sample);
      a_orig <= samples.original_sample;
      a_last <= samples.last;
    end
  end

  // Stage B: square the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (a_valid && b_ready) begin
      b_diff <= a_diff;
      b_orig <= a_orig;
      b_last <= a_last;
      b_mag  <= a_mag;
      b_sq   <= MulBits'(a_mag) * MulBits'(a_mag);
    end
  end

  // Statistics update; a dataset start drops the old sums and seeds the extremes
  always_comb begin
    idx                = first_flag ? '0 : element_count;
    element_count_next = (idx == '1) ? idx : idx + 1'b1;

    abs_base     = first_flag ? '0 : acc_abs;
    abs_sum      = {1'b0, abs_base} + (AccBits + 1)'(b_mag);
    acc_abs_next = abs_sum[AccBits] ? '1 : abs_sum[AccBits-1:0];

    sq_base     = first_flag ? '0 : acc_sq;
    sq_sum      = {1'b0, sq_base} + (SqBits + 1)'(b_sq);
    acc_sq_next = sq_sum[SqBits] ? '1 : sq_sum[SqBits-1:0];

    orig_base = first_flag ? '0 : acc_orig;
    orig_sum  = (AccBits + 1)'(orig_base) + (AccBits + 1)'(b_orig);
    if (orig_sum[AccBits] != orig_sum[AccBits-1]) begin
      acc_orig_next = orig_sum[AccBits] ? {1'b1, {(AccBits - 1){1'b0}}}
                                        : {1'b0, {(AccBits - 1){1'b1}}};
    end else begin
      acc_orig_next = orig_sum[AccBits-1:0];
    end

    if (first_flag) begin
      diff_low_next  = b_diff;
      diff_high_next = b_diff;
      orig_low_next  = b_orig;
      orig_high_next = b_orig;
    end else begin
      diff_low_next  = (b_diff < diff_low) ? b_diff : diff_low;
      diff_high_next = (b_diff > diff_high) ? b_diff : diff_high;
      orig_low_next  = (b_orig < orig_low) ? b_orig : orig_low;
      orig_high_next = (b_orig > orig_high) ? b_orig : orig_high;
    end

    // A tie moves the index to the later element
    diff_low_pos_next  = (b_diff == diff_low_next) ? idx : diff_low_pos;
    diff_high_pos_next = (b_diff == diff_high_next) ? idx : diff_high_pos;
  end

  // Result stage: load a new result and advance the statistics together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      first_flag <= 1'b1;
    end else begin
      if (out_free) begin
        out_valid <= b_valid;
      end
      if (b_valid && out_free) begin
        first_flag <= b_last;
      end
    end
    if (b_valid && out_free) begin
      out_diff      <= b_diff;
      out_last      <= b_last;
      element_count <= element_count_next;
      acc_abs       <= acc_abs_next;
      acc_orig      <= acc_orig_next;
      acc_sq        <= acc_sq_next;
      diff_low      <= diff_low_next;
      diff_high     <= diff_high_next;
      diff_low_pos  <= diff_low_pos_next;
      diff_high_pos <= diff_high_pos_next;
      orig_low      <= orig_low_next;
      orig_high     <= orig_high_next;
    end
  end

  // Drive the result channel
  assign results.valid          = out_valid;
  assign results.difference     = out_diff;
  assign results.final_res      = out_last;
  assign results.sum_abs_diff   = acc_abs;
  assign results.sum_orig       = acc_orig;
  assign results.sum_sq_diff    = acc_sq;
  assign results.min_diff       = diff_low;
  assign results.max_diff       = diff_high;
  assign results.min_diff_index = diff_low_pos;
  assign results.max_diff_index = diff_high_pos;
  assign results.min_orig       = orig_low;
  assign results.max_orig       = orig_high;

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The current difference always lies within the tracked extremes
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (diff_low <= out_diff) && (out_diff <= diff_high))
    else $error("difference outside tracked extremes");

  // Original extremes stay ordered
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (orig_low <= orig_high))
    else $error("original extremes out of order");

  // A dataset end always reopens the statistics for the next transfer
  assert property (@(posedge clk) disable iff (rst)
      (b_valid && out_free) |=> (first_flag == out_last))
    else $error("dataset start flag out of step with last result");

endmodule
